/* rtl/rss_pkg.sv */
// rss_pkg: field widths, record layout and sequencer state codes for the
// record selection sort block. No dependencies.
`timescale 1ns / 1ps

package rss_pkg;

  localparam int KEY_W = 32;
  localparam int TAG_W = 16;
  localparam int REC_W = KEY_W + TAG_W;

  // One-hot sequencer states
  typedef enum logic [7:0] {
    ST_LOAD  = 8'b0000_0001,
    ST_FETCH = 8'b0000_0010,
    ST_HOLD  = 8'b0000_0100,
    ST_SCAN  = 8'b0000_1000,
    ST_SWAP1 = 8'b0001_0000,
    ST_SWAP2 = 8'b0010_0000,
    ST_ORD   = 8'b0100_0000,
    ST_OWAIT = 8'b1000_0000
  } state_t;

  // Strict "better" test for the configured order
  function automatic logic better(input logic descending,
                                  input logic signed [KEY_W-1:0] cand,
                                  input logic signed [KEY_W-1:0] best);
    better = descending ? (cand > best) : (cand < best);
  endfunction

endpackage

/* rtl/rss_ram.sv */
// rss_ram: generic single write port, single read port RAM with a
// registered read. No dependencies.
`timescale 1ns / 1ps

module rss_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/record_selection_sort_top.sv */
// record_selection_sort_top: loads records into one RAM, sorts them there by
// selection sort and streams them out. Uses rss_pkg and rss_ram.
//
//   channel  | handshake           | word
//   ---------+---------------------+-----------------------------------------
//   input    | in_valid / in_ready | sort_key, record_tag, last_item
//   output   | out_valid/out_ready | out_key, out_tag, out_last, overflow
//   config   | cfg_we              | cfg_wdata (sort_order)
//
// Loading accepts one word per cycle. After the last word the set is sorted in
// place, one position i at a time: read the record at i, scan the rest for the
// best key, then swap if needed; all reads share the single RAM read port.
// Each output word is read from the RAM, then loaded into the output register.
// Reset (rst, synchronous) empties the store and sets ascending order.
// A stalled output word holds; the next set may load while the last word waits.
`timescale 1ns / 1ps

module record_selection_sort_top #(
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [rss_pkg::KEY_W-1:0] sort_key,
  input  logic        [rss_pkg::TAG_W-1:0] record_tag,
  input  logic                             last_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [rss_pkg::KEY_W-1:0] out_key,
  output logic        [rss_pkg::TAG_W-1:0] out_tag,
  output logic                             out_last,
  output logic                             overflow,
  input  logic                             cfg_we,
  input  logic                             cfg_wdata
);

  import rss_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  state_t          state;
  logic [CW-1:0]   count;     // records stored in this set
  logic            dropped;
  logic            sort_order;
  logic [CW-1:0]   n;         // records in the run
  logic            run_ovf;
  logic [CW-1:0]   i;         // position being filled
  logic [CW-1:0]   j;         // next scan read
  logic [CW-1:0]   sidx;      // index of the word now on rdata
  logic [CW-1:0]   k;         // best index so far
  logic [CW-1:0]   o;         // output position
  logic [REC_W-1:0] cur;      // record at position i
  logic [REC_W-1:0] best;     // best record so far

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [REC_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [REC_W-1:0] ram_rdata;

  logic in_acc;
  logic stored;
  logic out_free;
  logic cand_better;

  assign in_ready = (state == ST_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign stored   = (count < DEPTH_C);
  assign out_free = !out_valid || out_ready;
  assign cand_better = better(sort_order, $signed(ram_rdata[REC_W-1:TAG_W]),
                              $signed(best[REC_W-1:TAG_W]));

  rss_ram #(
    .WIDTH(REC_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // RAM port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = {sort_key, record_tag};
    ram_re    = 1'b0;
    ram_raddr = i[AW-1:0];
    unique case (state)
      ST_LOAD: begin
        ram_we = in_acc && stored;
      end
      ST_FETCH: begin
        ram_re = 1'b1;
      end
      ST_HOLD: begin
        ram_re    = 1'b1;
        ram_raddr = j[AW-1:0];
      end
      ST_SCAN: begin
        ram_re    = (j < n);
        ram_raddr = j[AW-1:0];
      end
      ST_SWAP1: begin
        ram_we    = (k != i);
        ram_waddr = i[AW-1:0];
        ram_wdata = best;
      end
      ST_SWAP2: begin
        ram_we    = 1'b1;
        ram_waddr = k[AW-1:0];
        ram_wdata = cur;
      end
      ST_ORD: begin
        ram_re    = 1'b1;
        ram_raddr = o[AW-1:0];
      end
      ST_OWAIT: begin
        ram_re = 1'b0;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      sort_order <= 1'b0;
    end else if (cfg_we) begin
      sort_order <= cfg_wdata;
    end
  end

  // sequencer: load, sort in place, stream out
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (last_item) begin
              n       <= stored ? count + 1'b1 : count;
              run_ovf <= dropped || !stored;
              count   <= '0;
              dropped <= 1'b0;
              i       <= '0;
              state   <= ST_FETCH;
            end else if (stored) begin
              count <= count + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
          end
        end
        ST_FETCH: begin
          j <= i + 1'b1;
          if (CW'(i + 1'b1) >= n) begin
            o     <= '0;
            state <= ST_ORD;
          end else begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          cur   <= ram_rdata;
          best  <= ram_rdata;
          k     <= i;
          sidx  <= j;
          j     <= j + 1'b1;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (cand_better) begin
            best <= ram_rdata;
            k    <= sidx;
          end
          if (j < n) begin
            sidx <= j;
            j    <= j + 1'b1;
          end else begin
            state <= ST_SWAP1;
          end
        end
        ST_SWAP1: begin
          if (k != i) begin
            state <= ST_SWAP2;
          end else begin
            i     <= i + 1'b1;
            state <= ST_FETCH;
          end
        end
        ST_SWAP2: begin
          i     <= i + 1'b1;
          state <= ST_FETCH;
        end
        ST_ORD: begin
          state <= ST_OWAIT;
        end
        ST_OWAIT: begin
          if (out_free) begin
            o         <= o + 1'b1;
            state     <= (CW'(o + 1'b1) == n) ? ST_LOAD : ST_ORD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // output valid: set when a word is loaded, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OWAIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (state == ST_OWAIT && out_free) begin
      out_key  <= $signed(ram_rdata[REC_W-1:TAG_W]);
      out_tag  <= ram_rdata[TAG_W-1:0];
      out_last <= (CW'(o + 1'b1) == n);
      overflow <= run_ovf;
    end
  end

endmodule

/* rtl/rss_checker.sv */
// rss_checker: port-level checks on record_selection_sort_top, bound to it.
// Uses rss_pkg.
`timescale 1ns / 1ps

module rss_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             last_item,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [rss_pkg::KEY_W-1:0] out_key,
  input logic        [rss_pkg::TAG_W-1:0] out_tag,
  input logic                             out_last
);

  import rss_pkg::*;

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_tag)
                                && $stable(out_last))
    else $error("stalled output word changed");

  // a non-final input word keeps the block loading
  a_load_cont: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !last_item |=> in_ready)
    else $error("input stalled after a non-final word");

  // the final input word starts the sort
  a_load_stop: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_item |=> !in_ready)
    else $error("input still open after the final word");

endmodule

bind record_selection_sort_top rss_checker u_rss_checker (.*);

/* bench/tb_record_selection_sort_top.sv */
// Self-checking bench for record_selection_sort_top: loads sets of keyed records in both
// sort orders and checks every sorted word against a behavioral selection sort.
// Depends on rss_pkg and the record_selection_sort_top RTL.
`timescale 1ns / 1ps

module tb_record_selection_sort_top;

  localparam int DEPTH        = 32;
  localparam int KW           = rss_pkg::KEY_W;
  localparam int TW           = rss_pkg::TAG_W;
  localparam int LIMIT_CYCLES = 500000;
  localparam int SETTLE       = 64;
  localparam bit ASCENDING    = 1'b0;
  localparam bit DESCENDING   = 1'b1;

  // Directed set: extremes, zero, minus one and repeated keys
  localparam logic signed [KW-1:0] DIR_KEYS [8] = '{
    32'sd0, 32'sh8000_0000, 32'sh7fff_ffff, -32'sd1,
    32'sd5, 32'sd5, 32'sh8000_0000, 32'sd5
  };
  localparam logic [TW-1:0] DIR_TAGS [8] = '{
    16'hffff, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'h0006, 16'h0000
  };

  typedef struct packed {
    logic signed [KW-1:0] key;
    logic [TW-1:0]        tag;
    logic                 last;
  } rec_word_t;

  typedef struct packed {
    logic signed [KW-1:0] key;
    logic [TW-1:0]        tag;
    logic                 last;
    logic                 ovf;
  } sorted_word_t;

  logic                 clk;
  logic                 rst        = 1'b1;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic signed [KW-1:0] sort_key   = '0;
  logic [TW-1:0]        record_tag = '0;
  logic                 last_item  = 1'b0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic signed [KW-1:0] out_key;
  logic [TW-1:0]        out_tag;
  logic                 out_last;
  logic                 overflow;
  logic                 cfg_we     = 1'b0;
  logic                 cfg_wdata  = 1'b0;

  // Bench-side copy of the block state
  logic signed [KW-1:0] held_key [DEPTH];
  logic [TW-1:0]        held_tag [DEPTH];
  int                   held_cnt  = 0;
  bit                   held_drop = 1'b0;
  bit                   order_q   = ASCENDING;

  rec_word_t    load_queue [$];
  sorted_word_t sorted_words [$];
  sorted_word_t got_w;
  sorted_word_t exp_w;

  int  errors        = 0;
  int  words_checked = 0;
  int  sets_done     = 0;
  int  drop_sets     = 0;
  int  cycles        = 0;
  int  gap_left      = 0;
  int  stall_left    = 0;
  bit  quiet         = 1'b0;

  record_selection_sort_top #(.DEPTH(DEPTH)) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sort_key   (sort_key),
    .record_tag (record_tag),
    .last_item  (last_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_key    (out_key),
    .out_tag    (out_tag),
    .out_last   (out_last),
    .overflow   (overflow),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [KW-1:0] rand_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom;
    if (r < 70) return int'($urandom_range(0, 8)) - 4;   // dense: many equal keys
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return (int'($urandom_range(0, 2000)) - 1000) * 256;  // Q23.8 values
  endfunction

  // Set size: mostly small, some exactly full, a few past capacity
  function automatic int pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(1, 6);
    if (r < 78) return $urandom_range(7, 20);
    if (r < 86) return DEPTH;
    if (r < 92) return $urandom_range(DEPTH + 1, DEPTH + 4);
    return $urandom_range(21, DEPTH - 1);
  endfunction

  task automatic push_word(input logic signed [KW-1:0] key, input logic [TW-1:0] tag,
                           input logic last);
    rec_word_t w;
    w.key  = key;
    w.tag  = tag;
    w.last = last;
    load_queue.push_back(w);
  endtask

  task automatic add_set(input int n);
    for (int i = 0; i < n; i++) push_word(rand_key(), 16'($urandom), i == n - 1);
  endtask

  // Store one record; on the final one, selection sort and queue the run
  task automatic take_record(input logic signed [KW-1:0] key, input logic [TW-1:0] tag,
                             input logic last);
    int                   best;
    logic signed [KW-1:0] tk;
    logic [TW-1:0]        tt;
    sorted_word_t         w;
    if (held_cnt < DEPTH) begin
      held_key[held_cnt] = key;
      held_tag[held_cnt] = tag;
      held_cnt++;
    end else begin
      held_drop = 1'b1;
    end
    if (last) begin
      for (int i = 0; i + 1 < held_cnt; i++) begin
        best = i;
        for (int j = i + 1; j < held_cnt; j++) begin
          if (order_q ? (held_key[j] > held_key[best]) : (held_key[j] < held_key[best]))
            best = j;
        end
        if (best != i) begin
          tk = held_key[i];
          tt = held_tag[i];
          held_key[i] = held_key[best];
          held_tag[i] = held_tag[best];
          held_key[best] = tk;
          held_tag[best] = tt;
        end
      end
      for (int i = 0; i < held_cnt; i++) begin
        w.key  = held_key[i];
        w.tag  = held_tag[i];
        w.last = (i == held_cnt - 1);
        w.ovf  = held_drop;
        sorted_words.push_back(w);
      end
      sets_done++;
      if (held_drop) drop_sets++;
      held_cnt  = 0;
      held_drop = 1'b0;
    end
  endtask

  task automatic log_mismatch(input string why, input sorted_word_t e, input sorted_word_t a);
    errors++;
    if (errors <= 10) begin
      $display("MISMATCH (%s): expected key=%0d tag=%h last=%b ovf=%b",
               why, e.key, e.tag, e.last, e.ovf);
      $display("  got key=%0d tag=%h last=%b ovf=%b", a.key, a.tag, a.last, a.ovf);
    end
  endtask

  // Order register write; only called with the block idle
  task automatic set_order(input bit v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    order_q = v;
  endtask

  // Wait until every queued word is sent and every sorted word is back
  task automatic drain();
    do @(posedge clk);
    while (load_queue.size() != 0 || in_valid || sorted_words.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Input driver: holds a word until taken, random gaps between words
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) take_record(sort_key, record_tag, last_item);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (load_queue.size() != 0) begin
          rec_word_t w;
          w = load_queue.pop_front();
          sort_key   <= w.key;
          record_tag <= w.tag;
          last_item  <= w.last;
          in_valid   <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output backpressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_w.key  = out_key;
      got_w.tag  = out_tag;
      got_w.last = out_last;
      got_w.ovf  = overflow;
      if (sorted_words.size() == 0) begin
        log_mismatch("unexpected word", '0, got_w);
      end else begin
        exp_w = sorted_words.pop_front();
        if (got_w.key !== exp_w.key || got_w.tag !== exp_w.tag ||
            got_w.last !== exp_w.last || got_w.ovf !== exp_w.ovf)
          log_mismatch("field", exp_w, got_w);
      end
      words_checked++;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d sorted words still outstanding",
               cycles, sorted_words.size());
      $display("record_selection_sort_top test failed");
      $finish;
    end
  end

  initial begin
    int n;
    int phase_items;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: single record at max key, then extremes and ties ascending
    set_order(ASCENDING);
    push_word(32'sh7fff_ffff, 16'hffff, 1'b1);
    for (int i = 0; i < 8; i++) push_word(DIR_KEYS[i], DIR_TAGS[i], i == 7);
    drain();

    // Same set descending
    set_order(DESCENDING);
    for (int i = 0; i < 8; i++) push_word(DIR_KEYS[i], DIR_TAGS[i], i == 7);
    drain();

    // Random phases; the first two each open with an over-capacity set
    for (int p = 0; p < 4; p++) begin
      set_order((p == 1 || p == 2) ? DESCENDING : ASCENDING);
      quiet = (p == 2);
      phase_items = 0;
      if (p < 2) begin
        n = $urandom_range(DEPTH + 1, DEPTH + 4);
        add_set(n);
        phase_items += n;
      end
      while (phase_items < 38) begin
        n = pick_size();
        add_set(n);
        phase_items += n;
      end
      drain();
    end

    errors += sorted_words.size();
    $display("Summary: %0d sets sorted (%0d with dropped records), %0d words checked",
             sets_done, drop_sets, words_checked);
    $display("Both orders exercised, with bursts and random stalls on input and output");
    if (errors == 0) begin
      $display("record_selection_sort_top test passed");
    end else begin
      $display("record_selection_sort_top test failed");
    end
    $finish;
  end

endmodule
